FILE: hw/rtl/coap_option_stream_parser_core_macros.svh
// Assertion macros for the option stream parser core.
// Used by the top level only; no other dependencies.
`ifndef COAP_OPTION_STREAM_PARSER_CORE_MACROS_SVH
`define COAP_OPTION_STREAM_PARSER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define COSP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define COSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/cosp_pkg.sv
// Shared types and constants of the option stream parser core.
// No dependencies; used by every module of the block.
`default_nettype none

package cosp_pkg;

  localparam int MAX_OPTIONS_DEFAULT = 16;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [1:0] KIND_OPTION = 2'd0;
  localparam logic [1:0] KIND_END    = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [1:0] ERR_BAD_OPTION  = 2'd0;
  localparam logic [1:0] ERR_TOO_MANY    = 2'd1;
  localparam logic [1:0] ERR_TOO_LONG    = 2'd2;

  localparam logic [3:0]  NIB_EXT1       = 4'd13;
  localparam logic [3:0]  NIB_EXT2       = 4'd14;
  localparam logic [3:0]  NIB_RESERVED   = 4'hF;
  localparam logic [16:0] EXT1_BASE      = 17'd13;
  localparam logic [16:0] EXT2_BASE      = 17'd269;
  localparam logic [7:0]  PAYLOAD_MARKER = 8'hFF;
  localparam logic [15:0] POS_LIMIT      = 16'hFFFF;

  // One queue entry: the results that one byte causes, at most two.
  typedef struct packed {
    logic        has_first;
    logic [1:0]  first_kind;
    logic [15:0] opt_num;
    logic [16:0] value_length;
    logic [15:0] option_offset;
    logic [16:0] opt_span;
    logic [1:0]  error_code;
    logic        has_end;
    logic        end_ok;
    logic [15:0] body_size;
  } event_t;

endpackage

`default_nettype wire

FILE: hw/rtl/cosp_front.sv
// Front part: decodes option headers byte by byte and builds queue entries.
// Depends on cosp_pkg.
`default_nettype none

module cosp_front #(
  parameter int MAX_OPTIONS = cosp_pkg::MAX_OPTIONS_DEFAULT
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic [7:0]      data_byte,
  input  wire logic            final_byte,
  output cosp_pkg::event_t     ev,
  output logic                 ev_push
);

  typedef enum logic [2:0] {
    PH_HEADER, PH_DEXT1, PH_DEXT2, PH_LEXT1, PH_LEXT2, PH_VALUE, PH_PAYLOAD, PH_SKIP
  } phase_t;

  localparam logic [7:0] OPT_LIMIT = 8'(MAX_OPTIONS);

  phase_t      phase, phase_next;
  logic [3:0]  delta_nib, delta_nib_next;
  logic [3:0]  len_nib, len_nib_next;
  logic [7:0]  ext_high, ext_high_next;
  logic [16:0] cur_delta, cur_delta_next;
  logic [16:0] cur_len, cur_len_next;
  logic [16:0] bytes_left, bytes_left_next;
  logic [15:0] run_number, run_number_next;
  logic [7:0]  opts_seen, opts_seen_next;
  logic [15:0] byte_pos, byte_pos_next;
  logic [15:0] hdr_start, hdr_start_next;
  logic [15:0] pay_count, pay_count_next;

  logic go_length, go_value, done, bad, err;

  always_comb begin
    phase_next      = phase;
    delta_nib_next  = delta_nib;
    len_nib_next    = len_nib;
    ext_high_next   = ext_high;
    cur_delta_next  = cur_delta;
    cur_len_next    = cur_len;
    bytes_left_next = bytes_left;
    run_number_next = run_number;
    opts_seen_next  = opts_seen;
    byte_pos_next   = byte_pos;
    hdr_start_next  = hdr_start;
    pay_count_next  = pay_count;
    go_length       = 1'b0;
    go_value        = 1'b0;
    done            = 1'b0;
    bad             = 1'b0;
    err             = 1'b0;
    ev              = '0;

    if (accept && phase != PH_SKIP) begin
      if (byte_pos == cosp_pkg::POS_LIMIT) begin
        ev.has_first  = 1'b1;
        ev.first_kind = cosp_pkg::KIND_ERROR;
        ev.error_code = cosp_pkg::ERR_TOO_LONG;
        phase_next    = PH_SKIP;
      end else begin
        byte_pos_next = byte_pos + 16'd1;
        case (phase)
          PH_HEADER: begin
            hdr_start_next = byte_pos;
            if (data_byte == cosp_pkg::PAYLOAD_MARKER) begin
              phase_next = PH_PAYLOAD;
            end else begin
              delta_nib_next = data_byte[7:4];
              len_nib_next   = data_byte[3:0];
              if (data_byte[7:4] == cosp_pkg::NIB_RESERVED ||
                  data_byte[3:0] == cosp_pkg::NIB_RESERVED) begin
                bad = 1'b1;
              end else if (data_byte[7:4] >= cosp_pkg::NIB_EXT1) begin
                phase_next = PH_DEXT1;
              end else begin
                cur_delta_next = {13'd0, data_byte[7:4]};
                go_length      = 1'b1;
              end
            end
          end
          PH_DEXT1: begin
            if (delta_nib == cosp_pkg::NIB_EXT1) begin
              cur_delta_next = cosp_pkg::EXT1_BASE + {9'd0, data_byte};
              go_length      = 1'b1;
            end else begin
              ext_high_next = data_byte;
              phase_next    = PH_DEXT2;
            end
          end
          PH_DEXT2: begin
            cur_delta_next = cosp_pkg::EXT2_BASE + {1'b0, ext_high, data_byte};
            go_length      = 1'b1;
          end
          PH_LEXT1: begin
            if (len_nib == cosp_pkg::NIB_EXT1) begin
              cur_len_next = cosp_pkg::EXT1_BASE + {9'd0, data_byte};
              go_value     = 1'b1;
            end else begin
              ext_high_next = data_byte;
              phase_next    = PH_LEXT2;
            end
          end
          PH_LEXT2: begin
            cur_len_next = cosp_pkg::EXT2_BASE + {1'b0, ext_high, data_byte};
            go_value     = 1'b1;
          end
          PH_VALUE: begin
            if (bytes_left <= 17'd1) begin
              bytes_left_next = '0;
              done            = 1'b1;
            end else begin
              bytes_left_next = bytes_left - 17'd1;
            end
          end
          PH_PAYLOAD: pay_count_next = pay_count + 16'd1;
          default: ;
        endcase

        if (go_length) begin
          if (len_nib_next == cosp_pkg::NIB_EXT1 || len_nib_next == cosp_pkg::NIB_EXT2) begin
            phase_next = PH_LEXT1;
          end else begin
            cur_len_next = {13'd0, len_nib_next};
            go_value     = 1'b1;
          end
        end
        if (go_value) begin
          if (cur_len_next == '0) begin
            done = 1'b1;
          end else begin
            bytes_left_next = cur_len_next;
            phase_next      = PH_VALUE;
          end
        end

        if (done) begin
          phase_next      = PH_HEADER;
          run_number_next = run_number + cur_delta_next[15:0];
          ev.has_first    = 1'b1;
          if (opts_seen >= OPT_LIMIT) begin
            ev.first_kind = cosp_pkg::KIND_ERROR;
            ev.error_code = cosp_pkg::ERR_TOO_MANY;
            err           = 1'b1;
          end else begin
            ev.first_kind    = cosp_pkg::KIND_OPTION;
            ev.opt_num       = run_number_next;
            ev.value_length  = cur_len_next;
            ev.option_offset = hdr_start_next;
            ev.opt_span      = {1'b0, byte_pos_next - hdr_start_next};
            opts_seen_next   = opts_seen + 8'd1;
          end
        end
        if (bad) begin
          ev.has_first  = 1'b1;
          ev.first_kind = cosp_pkg::KIND_ERROR;
          ev.error_code = cosp_pkg::ERR_BAD_OPTION;
          err           = 1'b1;
        end

        // A final byte that leaves a header or value open is a truncation.
        if (!err && final_byte) begin
          ev.has_end   = 1'b1;
          ev.end_ok    = (phase_next == PH_HEADER) || (phase_next == PH_PAYLOAD);
          ev.body_size = ev.end_ok ? pay_count_next : 16'd0;
        end
        if (err) begin
          phase_next = PH_SKIP;
        end
      end
    end

    if (accept && final_byte) begin
      phase_next      = PH_HEADER;
      delta_nib_next  = '0;
      len_nib_next    = '0;
      ext_high_next   = '0;
      cur_delta_next  = '0;
      cur_len_next    = '0;
      bytes_left_next = '0;
      run_number_next = '0;
      opts_seen_next  = '0;
      byte_pos_next   = '0;
      hdr_start_next  = '0;
      pay_count_next  = '0;
    end
  end

  assign ev_push = accept && (ev.has_first || ev.has_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEADER;
      delta_nib  <= '0;
      len_nib    <= '0;
      ext_high   <= '0;
      cur_delta  <= '0;
      cur_len    <= '0;
      bytes_left <= '0;
      run_number <= '0;
      opts_seen  <= '0;
      byte_pos   <= '0;
      hdr_start  <= '0;
      pay_count  <= '0;
    end else begin
      phase      <= phase_next;
      delta_nib  <= delta_nib_next;
      len_nib    <= len_nib_next;
      ext_high   <= ext_high_next;
      cur_delta  <= cur_delta_next;
      cur_len    <= cur_len_next;
      bytes_left <= bytes_left_next;
      run_number <= run_number_next;
      opts_seen  <= opts_seen_next;
      byte_pos   <= byte_pos_next;
      hdr_start  <= hdr_start_next;
      pay_count  <= pay_count_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/cosp_queue.sv
// Short queue of decoded entries between the front and back parts.
// Depends on cosp_pkg.
`default_nettype none

module cosp_queue #(
  parameter int DEPTH = cosp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire cosp_pkg::event_t wr_data,
  input  wire logic             rd_en,
  output cosp_pkg::event_t      rd_data,
  output logic                  is_full,
  output logic                  is_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  cosp_pkg::event_t entries [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign is_full  = (count == CW'(DEPTH));
  assign is_empty = (count == '0);
  assign rd_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + AW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + AW'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CW'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/cosp_back.sv
// Back part: turns each queue entry into one or two result beats.
// Depends on cosp_pkg.
`default_nettype none

module cosp_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cosp_pkg::event_t head,
  input  wire logic             q_empty,
  output logic                  q_pop,
  input  wire logic             pop,
  output logic                  empty,
  output logic [1:0]            kind,
  output logic [15:0]           opt_num,
  output logic [16:0]           value_length,
  output logic [15:0]           option_offset,
  output logic [16:0]           opt_span,
  output logic [15:0]           body_size,
  output logic [1:0]            error_code,
  output logic                  last_result
);

  // Set once the first result of a two-result entry has been taken.
  logic second;
  logic show_end;
  logic take;

  assign show_end = second || !head.has_first;
  assign take     = pop && !q_empty;
  assign empty    = q_empty;
  assign q_pop    = take && (show_end || !head.has_end);

  always_comb begin
    if (show_end) begin
      kind          = head.end_ok ? cosp_pkg::KIND_END : cosp_pkg::KIND_ERROR;
      opt_num       = '0;
      value_length  = '0;
      option_offset = '0;
      opt_span      = '0;
      body_size     = head.body_size;
      error_code    = cosp_pkg::ERR_BAD_OPTION;
      last_result   = 1'b1;
    end else begin
      kind          = head.first_kind;
      opt_num       = head.opt_num;
      value_length  = head.value_length;
      option_offset = head.option_offset;
      opt_span      = head.opt_span;
      body_size     = '0;
      error_code    = head.error_code;
      last_result   = !head.has_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      second <= 1'b0;
    end else if (take) begin
      second <= !q_pop;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/coap_option_stream_parser_core.sv
// Option area parser for CoAP-style messages, one byte per beat.
//
// Input channel: a beat carries data_byte and final_byte and is taken when
// push is high and full is low. Result channel: while empty is low the oldest
// result stands on the result ports; pop with empty low takes it.
// Each byte yields zero, one or two results; last_result marks the last one
// of a byte. An option record comes from the last byte of its option: the
// last value byte, or the last header or extension byte when the value is
// empty; a final byte adds an end or error record after it. With nothing
// waiting, the results of a byte are on the ports in the cycle after its
// beat. Throughput: one byte per cycle while full is low; a byte with two
// results takes two pop beats on the result side.
// The decoder and the result side are parted by a queue of QUEUE_DEPTH
// entries, so either side may stall alone; full rises only when the queue
// holds QUEUE_DEPTH undelivered bytes' worth of results.
// Reset clears the parser state and the queue; no clearing pass is needed.
// Depends on cosp_pkg, cosp_front, cosp_queue, cosp_back and the macro header.
`default_nettype none

`include "coap_option_stream_parser_core_macros.svh"

module coap_option_stream_parser_core #(
  parameter int MAX_OPTIONS = cosp_pkg::MAX_OPTIONS_DEFAULT,
  parameter int QUEUE_DEPTH = cosp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte,
  input  wire logic        final_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       kind,
  output logic [15:0]      opt_num,
  output logic [16:0]      value_length,
  output logic [15:0]      option_offset,
  output logic [16:0]      opt_span,
  output logic [15:0]      body_size,
  output logic [1:0]       error_code,
  output logic             last_result
);

  cosp_pkg::event_t ev, head;
  logic accept, ev_push, q_pop, q_empty;

  assign accept = push && !full;

  cosp_front #(
    .MAX_OPTIONS(MAX_OPTIONS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .ev         (ev),
    .ev_push    (ev_push)
  );

  cosp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (ev_push),
    .wr_data  (ev),
    .rd_en    (q_pop),
    .rd_data  (head),
    .is_full  (full),
    .is_empty (q_empty)
  );

  cosp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .pop           (pop),
    .empty         (empty),
    .kind          (kind),
    .opt_num       (opt_num),
    .value_length  (value_length),
    .option_offset (option_offset),
    .opt_span      (opt_span),
    .body_size     (body_size),
    .error_code    (error_code),
    .last_result   (last_result)
  );

  `COSP_ASSERT_NEXT(a_pair_follows, pop && !empty && !last_result, !empty && (kind == cosp_pkg::KIND_END || kind == cosp_pkg::KIND_ERROR), "second result of a byte missing")
  `COSP_ASSERT_SAME(a_full_not_empty, full, !empty, "queue full but no result shown")
  `COSP_ASSERT_SAME(a_record_size, !empty && kind == cosp_pkg::KIND_OPTION, opt_span != '0, "option record with zero size")

endmodule

`default_nettype wire
